// ===== rtl/prism_to_tetra_split_defines.svh =====
// assertion macros shared by the prism split rtl
`ifndef PRISM_TO_TETRA_SPLIT_DEFINES_SVH
`define PRISM_TO_TETRA_SPLIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define P2T_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2t assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define P2T_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2t assertion failed");

`endif

// ===== rtl/p2t_pkg.sv =====
// types and constant tables for the prism to tetrahedra splitter
package p2t_pkg;

  localparam int CORNER_W = 32;
  localparam int VERT_W   = 32;
  localparam int NUM_CORN = 6;
  localparam int NUM_TET  = 3;

  localparam logic [1:0] TET_FIRST = 2'd0;
  localparam logic [1:0] TET_LAST  = 2'd2;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_0;
    logic [CORNER_W-1:0] corner_1;
    logic [CORNER_W-1:0] corner_2;
    logic [CORNER_W-1:0] corner_3;
    logic [CORNER_W-1:0] corner_4;
    logic [CORNER_W-1:0] corner_5;
  } p2t_in_t;

  typedef struct packed {
    logic [1:0]        tet_number;
    logic [VERT_W-1:0] tet_vertex_a;
    logic [VERT_W-1:0] tet_vertex_b;
    logic [VERT_W-1:0] tet_vertex_c;
    logic [VERT_W-1:0] tet_vertex_d;
    logic              split_error;
    logic              last_of_prism;
  } p2t_out_t;

  // row r: local vertex k (0-based) -> corner number, used when corner r is the minimum
  localparam logic [2:0] RELABEL [NUM_CORN][NUM_CORN] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3},
    '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4},
    '{3'd3, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1},
    '{3'd4, 3'd3, 3'd5, 3'd1, 3'd0, 3'd2},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
  };

  // local vertices (0-based) of each tetrahedron, quad cut along local 1-5
  localparam logic [2:0] TET_D26 [NUM_TET][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd0, 3'd4, 3'd5, 3'd3}
  };

  // same, quad cut along local 2-4
  localparam logic [2:0] TET_D35 [NUM_TET][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd4},
    '{3'd0, 3'd4, 3'd2, 3'd5},
    '{3'd0, 3'd4, 3'd5, 3'd3}
  };

endpackage

// ===== rtl/prism_to_tetra_split.sv =====
// top level: splits one prism into three tetrahedra by the minimum vertex rule
//
//   channel | ports                          | direction | one transfer carries
//   --------+--------------------------------+-----------+----------------------------
//   input   | in_valid, in_ready, in_data    | in        | six corner indices of a prism
//   result  | out_valid, out_ready, out_data | out       | one tetrahedron or one error
//
// a prism takes three transfers on the result channel (one when it cannot be split);
// that count is set by the single result port, one tetrahedron per transfer.
// a prism passes through the input register, then the analysis register, before its
// first result; the next prism waits in the input register meanwhile.
// rst_n is synchronous, active low, and clears the valid flags and the counter.
// stalls on out_ready hold the current result; in_ready stays high while the
// input register is free or is being drained into the analysis stage.

`include "prism_to_tetra_split_defines.svh"

module prism_to_tetra_split
  import p2t_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  p2t_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output p2t_out_t out_data
);

  // inputs are 32 bits wide, so indices above that width change nothing
  localparam int CMP_W = (INDEX_BITS < CORNER_W) ? INDEX_BITS : CORNER_W;

  // ---------------- stage a: input register (masked corners) ----------------
  logic             a_valid_r, a_valid_nxt;
  logic [CMP_W-1:0] a_c_r [NUM_CORN];

  // ---------------- stage b: relabeled prism and emit counter ---------------
  logic             b_valid_r, b_valid_nxt;
  logic [CMP_W-1:0] b_p_r [NUM_CORN];
  logic [CMP_W-1:0] b_p_nxt [NUM_CORN];
  logic             b_use26_r, b_use26_nxt;
  logic             b_err_r, b_err_nxt;
  logic [1:0]       b_cnt_r, b_cnt_nxt;

  // handshake
  logic in_fire, out_fire, out_last, b_done, b_load;

  // analysis of the prism in stage a
  logic [NUM_CORN-1:0] lt [NUM_CORN];
  logic [NUM_CORN-1:0] strict;
  logic [NUM_CORN-1:0] lt26, lt35;
  logic [2:0]          min_idx;
  logic                any_strict, diag26, diag35;

  // result selection
  logic [2:0] vsel [4];

  // ---------------- handshake ----------------
  assign out_valid = b_valid_r;
  assign out_last  = b_err_r || (b_cnt_r == TET_LAST);
  assign out_fire  = b_valid_r && out_ready;
  assign b_done    = out_fire && out_last;
  // stage b takes the next prism once the current one has sent its last transfer
  assign b_load    = a_valid_r && (!b_valid_r || b_done);
  assign in_ready  = !a_valid_r || b_load;
  assign in_fire   = in_valid && in_ready;

  // ---------------- analysis: all comparisons in parallel ----------------
  always_comb begin
    for (int i = 0; i < NUM_CORN; i++) begin
      for (int j = 0; j < NUM_CORN; j++) begin
        lt[i][j] = (i != j) && (a_c_r[i] < a_c_r[j]);
      end
    end
    // a corner is the strict minimum when it is below all five others
    for (int i = 0; i < NUM_CORN; i++) begin
      strict[i] = &(lt[i] | (NUM_CORN'(1) << i));
    end
    // diagonal choice per candidate row, min(p2,p6) against min(p3,p5)
    // worked out from the pair compares: min(a,b) < min(c,d) iff a or b is below both
    for (int r = 0; r < NUM_CORN; r++) begin
      lt26[r] = (lt[RELABEL[r][1]][RELABEL[r][2]] && lt[RELABEL[r][1]][RELABEL[r][4]]) ||
                (lt[RELABEL[r][5]][RELABEL[r][2]] && lt[RELABEL[r][5]][RELABEL[r][4]]);
      lt35[r] = (lt[RELABEL[r][2]][RELABEL[r][1]] && lt[RELABEL[r][2]][RELABEL[r][5]]) ||
                (lt[RELABEL[r][4]][RELABEL[r][1]] && lt[RELABEL[r][4]][RELABEL[r][5]]);
    end
    // at most one corner can be strict
    min_idx = 3'd0;
    for (int i = NUM_CORN - 1; i >= 0; i--) begin
      if (strict[i]) begin
        min_idx = 3'(i);
      end
    end
    any_strict = |strict;
    diag26     = |(strict & lt26);
    diag35     = |(strict & lt35);
  end

  // ---------------- stage a and stage b next values ----------------
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end

    b_valid_nxt = b_valid_r;
    b_cnt_nxt   = b_cnt_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
      b_cnt_nxt   = TET_FIRST;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (out_fire) begin
      b_cnt_nxt = b_cnt_r + 2'd1;
    end

    for (int k = 0; k < NUM_CORN; k++) begin
      b_p_nxt[k] = a_c_r[RELABEL[min_idx][k]];
    end
    b_use26_nxt = diag26;
    // no strict minimum, or both diagonal minima equal
    b_err_nxt   = !any_strict || !(diag26 || diag35);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      b_cnt_r   <= TET_FIRST;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      b_cnt_r   <= b_cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_c_r[0] <= in_data.corner_0[CMP_W-1:0];
      a_c_r[1] <= in_data.corner_1[CMP_W-1:0];
      a_c_r[2] <= in_data.corner_2[CMP_W-1:0];
      a_c_r[3] <= in_data.corner_3[CMP_W-1:0];
      a_c_r[4] <= in_data.corner_4[CMP_W-1:0];
      a_c_r[5] <= in_data.corner_5[CMP_W-1:0];
    end
    if (b_load) begin
      b_p_r     <= b_p_nxt;
      b_use26_r <= b_use26_nxt;
      b_err_r   <= b_err_nxt;
    end
  end

  // ---------------- result: pick four local vertices of tetrahedron b_cnt_r ----------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vsel[k] = b_use26_r ? TET_D26[b_cnt_r][k] : TET_D35[b_cnt_r][k];
    end
    out_data.tet_number    = b_cnt_r;
    out_data.tet_vertex_a  = b_err_r ? '0 : VERT_W'(b_p_r[vsel[0]]);
    out_data.tet_vertex_b  = b_err_r ? '0 : VERT_W'(b_p_r[vsel[1]]);
    out_data.tet_vertex_c  = b_err_r ? '0 : VERT_W'(b_p_r[vsel[2]]);
    out_data.tet_vertex_d  = b_err_r ? '0 : VERT_W'(b_p_r[vsel[3]]);
    out_data.split_error   = b_err_r;
    out_data.last_of_prism = out_last;
  end

  // ---------------- assertions ----------------
  `P2T_ASSERT_NOW(a_err_single, b_valid_r && b_err_r, b_cnt_r == TET_FIRST)
  `P2T_ASSERT_NOW(a_cnt_range, b_valid_r, b_cnt_r != 2'd3)
  `P2T_ASSERT_NEXT(a_cnt_step, out_fire && !out_last, b_valid_r && (b_cnt_r == $past(b_cnt_r) + 2'd1))
  `P2T_ASSERT_NEXT(a_drain, b_done && !b_load, !b_valid_r)
  `P2T_ASSERT_NOW(a_no_overrun, b_load, !b_valid_r || b_done)

endmodule
